// ===== design/gsc_pkg.sv =====
// Shared types, codes and constants for the GET/SET command parser.
// No dependencies; compile first.
package gsc_pkg;

  localparam int ByteW  = 8;
  localparam int KindW  = 3;
  localparam int CauseW = 2;
  localparam int PhaseW = 3;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_OP0  = 3'd0;
  localparam logic [PhaseW-1:0] PH_OP1  = 3'd1;
  localparam logic [PhaseW-1:0] PH_OP2  = 3'd2;
  localparam logic [PhaseW-1:0] PH_SEP  = 3'd3;
  localparam logic [PhaseW-1:0] PH_KEY  = 3'd4;
  localparam logic [PhaseW-1:0] PH_VAL  = 3'd5;
  localparam logic [PhaseW-1:0] PH_DONE = 3'd6;

  // Result kinds
  localparam logic [KindW-1:0] K_NONE  = 3'd0;
  localparam logic [KindW-1:0] K_KEY   = 3'd1;
  localparam logic [KindW-1:0] K_VALUE = 3'd2;
  localparam logic [KindW-1:0] K_GETOK = 3'd3;
  localparam logic [KindW-1:0] K_SETOK = 3'd4;
  localparam logic [KindW-1:0] K_ERROR = 3'd5;

  // Error causes
  localparam logic [CauseW-1:0] C_BADOP = 2'd0;
  localparam logic [CauseW-1:0] C_NOKEY = 2'd1;
  localparam logic [CauseW-1:0] C_NOVAL = 2'd2;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              get_match;
    logic              set_match;
    logic              field_started;
    logic              failed;
    logic [CauseW-1:0] fail_cause;
  } gsc_state_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  data;
    logic [CauseW-1:0] error_cause;
  } gsc_result_t;

  localparam gsc_state_t STATE_RESET = '{
    phase:         PH_OP0,
    get_match:     1'b1,
    set_match:     1'b1,
    field_started: 1'b0,
    failed:        1'b0,
    fail_cause:    C_BADOP
  };

  // Operator words, upper case, indexed by operator byte position
  function automatic logic [ByteW-1:0] get_char(input logic [1:0] idx);
    case (idx)
      2'd0:    get_char = 8'h47; // G
      2'd1:    get_char = 8'h45; // E
      default: get_char = 8'h54; // T
    endcase
  endfunction

  function automatic logic [ByteW-1:0] set_char(input logic [1:0] idx);
    case (idx)
      2'd0:    set_char = 8'h53; // S
      2'd1:    set_char = 8'h45; // E
      default: set_char = 8'h54; // T
    endcase
  endfunction

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    is_ws = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c);
    fold = ((c >= 8'h61) && (c <= 8'h7a)) ? (c - 8'd32) : c;
  endfunction

endpackage

// ===== design/gsc_if.sv =====
// Valid/ready channel interfaces for command bytes and parser results.
// Depends on gsc_pkg.
interface gsc_in_if;
  import gsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface gsc_out_if;
  import gsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [ByteW-1:0]  data;
  logic [CauseW-1:0] error_cause;

  modport source (output valid, output kind, output data, output error_cause, input ready);
  modport sink   (input valid, input kind, input data, input error_cause, output ready);
endinterface

// ===== design/gsc_step.sv =====
// Next-state and result logic for one command byte.
// Depends on gsc_pkg.
module gsc_step import gsc_pkg::*; (
  input  logic [ByteW-1:0] ch,
  input  gsc_state_t       cur,
  output gsc_state_t       nxt,
  output gsc_result_t      res
);

  logic             ws;
  logic [ByteW-1:0] f;

  assign ws = is_ws(ch);
  assign f  = fold(ch);

  always_comb begin
    nxt = cur;
    res = '0;
    if (ch == '0) begin
      // terminator: report verdict, return to reset state
      res.kind        = K_ERROR;
      res.error_cause = C_BADOP;
      if (cur.failed) begin
        res.error_cause = cur.fail_cause;
      end else begin
        case (cur.phase)
          PH_SEP: begin
            res.error_cause = (cur.get_match || cur.set_match) ? C_NOKEY : C_BADOP;
          end
          PH_KEY: begin
            if (!cur.field_started) res.error_cause = C_NOKEY;
            else if (cur.get_match) res.kind = K_GETOK;
            else res.error_cause = C_NOVAL;
          end
          PH_VAL: begin
            if (!cur.field_started) res.error_cause = C_NOVAL;
            else res.kind = K_SETOK;
          end
          PH_DONE: begin
            res.kind = cur.get_match ? K_GETOK : K_SETOK;
          end
          default: ;
        endcase
      end
      if (res.kind != K_ERROR) res.error_cause = C_BADOP;
      nxt = STATE_RESET;
    end else if (!cur.failed) begin
      case (cur.phase)
        PH_OP0, PH_OP1, PH_OP2: begin
          if (ws) begin
            nxt.failed     = 1'b1;
            nxt.fail_cause = C_BADOP;
          end else begin
            if (f != get_char(cur.phase[1:0])) nxt.get_match = 1'b0;
            if (f != set_char(cur.phase[1:0])) nxt.set_match = 1'b0;
            nxt.phase = cur.phase + 3'd1;
          end
        end
        PH_SEP: begin
          if (!ws || !(cur.get_match || cur.set_match)) begin
            nxt.failed     = 1'b1;
            nxt.fail_cause = C_BADOP;
          end else begin
            nxt.phase         = PH_KEY;
            nxt.field_started = 1'b0;
          end
        end
        PH_KEY: begin
          if (ws) begin
            nxt.phase         = cur.get_match ? PH_DONE : PH_VAL;
            nxt.field_started = 1'b0;
          end else begin
            nxt.field_started = 1'b1;
            res.kind          = K_KEY;
            res.data          = ch;
          end
        end
        PH_VAL: begin
          nxt.field_started = 1'b1;
          if (ws) begin
            nxt.phase = PH_DONE;
          end else begin
            res.kind = K_VALUE;
            res.data = ch;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/get_set_command_parser.sv =====
// GET/SET command parser, one result item per command byte.
// Result: registered, valid in the output register in the cycle after byte accept.
// Throughput: 1 byte per cycle while out_chan.ready is high; the output register refills in the cycle it drains.
// Reset: synchronous active-low rst_n clears parser state and output valid.
// Depends on gsc_pkg, gsc_if and gsc_step.
module get_set_command_parser import gsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gsc_in_if.sink     in_chan,
  gsc_out_if.source  out_chan
);

  gsc_state_t  state_r;
  gsc_state_t  state_nxt;
  gsc_result_t res_nxt;
  gsc_result_t res_r;
  logic        out_valid_r;
  logic        in_fire;

  gsc_step u_step (
    .ch  (in_chan.ch),
    .cur (state_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads on every accepted item
  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = res_r.kind;
  assign out_chan.data        = res_r.data;
  assign out_chan.error_cause = res_r.error_cause;

endmodule

// ===== design/gsc_checker.sv =====
// Port-level assertions for the GET/SET command parser, bound to the top level.
// Depends on gsc_pkg.
module gsc_checker import gsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KindW-1:0]  out_kind,
  input logic [ByteW-1:0]  out_data,
  input logic [CauseW-1:0] out_error_cause
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data)
      && $stable(out_error_cause))
    else $error("stalled result changed");

  // every accepted byte yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != K_KEY) && (out_kind != K_VALUE) |-> out_data == '0)
    else $error("data set on non-byte result");

  a_cause_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != K_ERROR) |-> out_error_cause == C_BADOP)
    else $error("cause set on non-error result");

endmodule

bind get_set_command_parser gsc_checker u_gsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_kind        (out_chan.kind),
  .out_data        (out_chan.data),
  .out_error_cause (out_chan.error_cause)
);
